[design/hnsu_pkg.sv]
// shared types and constants for the heightmap neighbour smoothing unit
// no dependencies
package hnsu_pkg;

    localparam int HEIGHT_BITS = 24;
    localparam int WEIGHT_BITS = 17;
    localparam int DIM_BITS    = 11;
    localparam int FRAC_BITS   = 16;

    localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = WEIGHT_BITS'(1) << FRAC_BITS;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_REGION_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BRUSH_MODE    = 2'd2;
    localparam logic [1:0] CFG_BLEND_FACTOR  = 2'd3;

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] height_in;
        logic [WEIGHT_BITS-1:0]        weight_in;
        logic                          padding;
    } hnsu_in_t;

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] smoothed_height;
        logic                          last_of_region;
    } hnsu_out_t;

    // which neighbours exist for a pixel, and what the item yields
    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
        logic emit;
        logic last;
    } hnsu_flags_t;

endpackage

[design/hnsu_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module hnsu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/hnsu_front.sv]
// front end: accepts items, tracks column and row, classifies neighbours
// depends on hnsu_pkg
module hnsu_front import hnsu_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int EW = (COL_W + 1 > DIM_BITS) ? COL_W + 1 : DIM_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [DIM_BITS-1:0]    region_width,
    input  logic [DIM_BITS-1:0]    region_height,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  hnsu_in_t               in_data,
    input  logic                   q_full,
    output logic                   push,
    output hnsu_flags_t            push_flags,
    output logic [COL_W-1:0]       push_col,
    output logic signed [HEIGHT_BITS-1:0] push_sample,
    output logic [WEIGHT_BITS-1:0] push_weight
);

    logic [COL_W-1:0]    col_reg;
    logic [DIM_BITS-1:0] row_reg;
    logic [EW-1:0]       eff_w;
    logic [EW-1:0]       col_inc;
    logic [DIM_BITS-1:0] eff_h;
    logic                flush;
    logic                accept;
    logic                row_end;

    always_comb
    begin
        if (region_width == '0)
        begin
            eff_w = EW'(1);
        end
        else if (EW'(region_width) > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(region_width);
        end
    end

    assign eff_h    = (region_height == '0) ? DIM_BITS'(1) : region_height;
    assign col_inc  = EW'(col_reg) + EW'(1);
    assign row_end  = col_inc >= eff_w;
    assign flush    = row_reg >= eff_h;
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    // early padding is swallowed without touching state
    assign push     = accept && !(in_data.padding && !flush);

    assign push_col    = col_reg;
    assign push_sample = in_data.height_in;
    assign push_weight = (in_data.weight_in > ONE_Q16) ? ONE_Q16 : in_data.weight_in;

    always_comb
    begin
        push_flags.left  = col_reg != '0;
        push_flags.right = !row_end;
        push_flags.up    = row_reg > DIM_BITS'(1);
        push_flags.down  = !flush;
        push_flags.emit  = row_reg != '0;
        push_flags.last  = flush && row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= flush ? '0 : row_reg + DIM_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

endmodule

[design/hnsu_queue.sv]
// two-entry queue of classified items between front and back
// depends on hnsu_pkg
module hnsu_queue import hnsu_pkg::*; #(
    parameter int COL_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hnsu_flags_t            push_flags,
    input  logic [COL_W-1:0]       push_col,
    input  logic signed [HEIGHT_BITS-1:0] push_sample,
    input  logic [WEIGHT_BITS-1:0] push_weight,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output hnsu_flags_t            head_flags,
    output logic [COL_W-1:0]       head_col,
    output logic signed [HEIGHT_BITS-1:0] head_sample,
    output logic [WEIGHT_BITS-1:0] head_weight
);

    hnsu_flags_t                   flags_reg  [2];
    logic [COL_W-1:0]              col_reg    [2];
    logic signed [HEIGHT_BITS-1:0] sample_reg [2];
    logic [WEIGHT_BITS-1:0]        weight_reg [2];
    logic                          wr_ptr_reg;
    logic                          rd_ptr_reg;
    logic [1:0]                    count_reg;

    assign full        = count_reg == 2'd2;
    assign head_valid  = count_reg != 2'd0;
    assign head_flags  = flags_reg[rd_ptr_reg];
    assign head_col    = col_reg[rd_ptr_reg];
    assign head_sample = sample_reg[rd_ptr_reg];
    assign head_weight = weight_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_reg[wr_ptr_reg]  <= push_flags;
            col_reg[wr_ptr_reg]    <= push_col;
            sample_reg[wr_ptr_reg] <= push_sample;
            weight_reg[wr_ptr_reg] <= push_weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[design/hnsu_back.sv]
// back end: line buffers, averaging sequencer with iterative divider, blend, output register
// depends on hnsu_pkg and hnsu_ram
module hnsu_back import hnsu_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   brush_mode,
    input  logic [WEIGHT_BITS-1:0] blend_factor,
    input  logic                   head_valid,
    input  hnsu_flags_t            head_flags,
    input  logic [COL_W-1:0]       head_col,
    input  logic signed [HEIGHT_BITS-1:0] head_sample,
    input  logic [WEIGHT_BITS-1:0] head_weight,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hnsu_out_t              out_data
);

    localparam int SUM_W = HEIGHT_BITS + 3;
    localparam int NW    = SUM_W + 1;
    localparam int CNT_W = $clog2(NW);
    localparam int DIF_W = SUM_W + 1;
    localparam int PRD_W = DIF_W + WEIGHT_BITS + 1;
    localparam int XW    = PRD_W + 1;
    localparam int TP_W  = 2 * WEIGHT_BITS;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RD_CTR   = 3'd1;
    localparam logic [2:0] ST_RD_RIGHT = 3'd2;
    localparam logic [2:0] ST_SUM      = 3'd3;
    localparam logic [2:0] ST_DIV      = 3'd4;
    localparam logic [2:0] ST_QUOT     = 3'd5;
    localparam logic [2:0] ST_FIN      = 3'd6;
    localparam logic [2:0] ST_OUT      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // current item
    hnsu_flags_t                   flags_reg;
    logic [COL_W-1:0]              col_reg;
    logic signed [HEIGHT_BITS-1:0] sample_reg;
    logic [WEIGHT_BITS-1:0]        weight_reg;

    // window around the centre pixel
    logic signed [HEIGHT_BITS-1:0] centre_reg;
    logic signed [HEIGHT_BITS-1:0] up_reg;
    logic signed [HEIGHT_BITS-1:0] right_reg;
    logic signed [HEIGHT_BITS-1:0] left_reg;
    logic [WEIGHT_BITS-1:0]        wt_reg;

    logic [TP_W-1:0]          tprod_reg;
    logic [WEIGHT_BITS-1:0]   t_reg;
    logic [NW-1:0]            shift_reg;
    logic [3:0]               rem_reg;
    logic [3:0]               dsor_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic signed [PRD_W-1:0]  prod_reg;
    logic signed [HEIGHT_BITS-1:0] res_reg;

    logic                     out_valid_reg;
    hnsu_out_t                out_data_reg;

    // ram ports
    logic                          buf_we;
    logic [COL_W-1:0]              prev_raddr;
    logic [HEIGHT_BITS-1:0]        prev_rdata;
    logic [HEIGHT_BITS-1:0]        older_rdata;
    logic [WEIGHT_BITS-1:0]        wgt_rdata;

    logic [WEIGHT_BITS-1:0]        f_eff;
    logic signed [SUM_W-1:0]       sum_c;
    logic [2:0]                    den_c;
    logic [SUM_W-1:0]              mag_c;
    logic [4:0]                    trial;
    logic                          q_bit;
    logic signed [SUM_W-1:0]       s_c;
    logic signed [XW-1:0]          x_c;
    logic [XW-1:0]                 xmag_c;
    logic [XW-1:0]                 xq_c;
    logic signed [HEIGHT_BITS-1:0] blend_c;
    logic                          out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = (state_reg == ST_IDLE) && head_valid;
    assign buf_we    = state_reg == ST_RD_RIGHT;
    assign prev_raddr = (state_reg == ST_IDLE) ? head_col : col_reg + COL_W'(1);
    assign f_eff     = (blend_factor > ONE_Q16) ? ONE_Q16 : blend_factor;

    hnsu_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_prev_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (col_reg),
        .wdata (sample_reg),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    hnsu_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_older_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (col_reg),
        .wdata (centre_reg),
        .raddr (head_col),
        .rdata (older_rdata)
    );

    hnsu_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_wgt_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (col_reg),
        .wdata (weight_reg),
        .raddr (head_col),
        .rdata (wgt_rdata)
    );

    // neighbour sum and divisor count
    always_comb
    begin
        sum_c = '0;
        if (flags_reg.left)
        begin
            sum_c = sum_c + SUM_W'(left_reg);
        end
        if (flags_reg.right)
        begin
            sum_c = sum_c + SUM_W'(right_reg);
        end
        if (flags_reg.up)
        begin
            sum_c = sum_c + SUM_W'(up_reg);
        end
        if (flags_reg.down)
        begin
            sum_c = sum_c + SUM_W'(sample_reg);
        end
        if (brush_mode)
        begin
            sum_c = sum_c + SUM_W'(centre_reg);
        end
        den_c = 3'(flags_reg.left) + 3'(flags_reg.right) + 3'(flags_reg.up)
              + 3'(flags_reg.down) + 3'(brush_mode);
        mag_c = (sum_c < 0) ? SUM_W'(-sum_c) : SUM_W'(sum_c);
    end

    // one restoring division step per cycle
    assign trial = {rem_reg, shift_reg[NW-1]};
    assign q_bit = trial >= {1'b0, dsor_reg};

    assign s_c = neg_reg ? -$signed({1'b0, shift_reg[SUM_W-2:0]})
                         : $signed({1'b0, shift_reg[SUM_W-2:0]});

    // blend: centre * 2^16 + (s - centre) * t, rounded back to q8.16
    always_comb
    begin
        x_c     = (XW'(centre_reg) <<< FRAC_BITS) + XW'(prod_reg);
        xmag_c  = (x_c < 0) ? XW'(-x_c) : XW'(x_c);
        xq_c    = (xmag_c + XW'(ONE_Q16 >> 1)) >> FRAC_BITS;
        blend_c = (x_c < 0) ? -$signed(xq_c[HEIGHT_BITS-1:0])
                            : $signed(xq_c[HEIGHT_BITS-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = ST_RD_CTR;
                end
            end
            ST_RD_CTR:   state_next = ST_RD_RIGHT;
            ST_RD_RIGHT: state_next = flags_reg.emit ? ST_SUM : ST_IDLE;
            ST_SUM:      state_next = (!brush_mode && den_c == 3'd0) ? ST_OUT : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:     state_next = brush_mode ? ST_FIN : ST_OUT;
            ST_FIN:      state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                flags_reg  <= head_flags;
                col_reg    <= head_col;
                sample_reg <= head_sample;
                weight_reg <= head_weight;
            end
            ST_RD_CTR:
            begin
                // left neighbour is the centre of the previous item in this row
                left_reg   <= centre_reg;
                centre_reg <= $signed(prev_rdata);
                up_reg     <= $signed(older_rdata);
                wt_reg     <= wgt_rdata;
            end
            ST_RD_RIGHT:
            begin
                right_reg <= $signed(prev_rdata);
                tprod_reg <= TP_W'(f_eff) * TP_W'(wt_reg);
            end
            ST_SUM:
            begin
                t_reg     <= WEIGHT_BITS'((tprod_reg + TP_W'(ONE_Q16 >> 1)) >> FRAC_BITS);
                shift_reg <= {mag_c, 1'b0} + NW'(den_c);
                dsor_reg  <= {den_c, 1'b0};
                rem_reg   <= '0;
                cnt_reg   <= '0;
                neg_reg   <= sum_c < 0;
                res_reg   <= centre_reg;
            end
            ST_DIV:
            begin
                rem_reg   <= q_bit ? 4'(trial - {1'b0, dsor_reg}) : trial[3:0];
                shift_reg <= {shift_reg[NW-2:0], q_bit};
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            ST_QUOT:
            begin
                res_reg  <= s_c[HEIGHT_BITS-1:0];
                prod_reg <= PRD_W'(DIF_W'(s_c) - DIF_W'(centre_reg))
                          * PRD_W'($signed({1'b0, t_reg}));
            end
            ST_FIN:
            begin
                res_reg <= blend_c;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_reg.smoothed_height <= res_reg;
                    out_data_reg.last_of_region  <= flags_reg.last;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_sum_only_for_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |-> flags_reg.emit)
        else $error("averaging started for an item without a result");

    a_div_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dsor_reg != 4'd0)
        else $error("divider running with zero divisor");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after output stage");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_RD_CTR)
        else $error("popped item not read from line buffers");

endmodule

[design/heightmap_neighbour_smoothing_unit.sv]
// top level of the heightmap neighbour smoothing unit: config registers, front, queue, back
// depends on hnsu_pkg, hnsu_front, hnsu_queue, hnsu_back, hnsu_ram
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid / in_stall    | in_data  (hnsu_in_t)
//  out      | output    | out_valid / out_stall  | out_data (hnsu_out_t)
//  cfg      | input     | cfg_write              | cfg_index, cfg_data
//
// an item without a result goes through idle, centre read and right read only; one with a result
// also goes through sum, the 28-step bit-serial divider, quotient, a blend step in brush mode, and output
// a lone pixel in plain mode skips the divider and goes from sum straight to output
// the front takes items while the two-entry queue has room, so it runs ahead
// reset is asynchronous, active low; line buffers are not cleared
// the output register lets the back end finish an item while a result waits
module heightmap_neighbour_smoothing_unit import hnsu_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  hnsu_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hnsu_out_t              out_data,
    input  logic                   cfg_write,
    input  logic [1:0]             cfg_index,
    input  logic [WEIGHT_BITS-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // configuration registers
    logic [DIM_BITS-1:0]    region_width_reg;
    logic [DIM_BITS-1:0]    region_height_reg;
    logic                   brush_mode_reg;
    logic [WEIGHT_BITS-1:0] blend_factor_reg;

    // front to queue
    logic                          push;
    hnsu_flags_t                   push_flags;
    logic [COL_W-1:0]              push_col;
    logic signed [HEIGHT_BITS-1:0] push_sample;
    logic [WEIGHT_BITS-1:0]        push_weight;
    logic                          q_full;

    // queue to back
    logic                          pop;
    logic                          head_valid;
    hnsu_flags_t                   head_flags;
    logic [COL_W-1:0]              head_col;
    logic signed [HEIGHT_BITS-1:0] head_sample;
    logic [WEIGHT_BITS-1:0]        head_weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_width_reg  <= DIM_BITS'(1024);
            region_height_reg <= DIM_BITS'(1024);
            brush_mode_reg    <= 1'b0;
            blend_factor_reg  <= ONE_Q16;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REGION_WIDTH:  region_width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_REGION_HEIGHT: region_height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_BRUSH_MODE:    brush_mode_reg    <= cfg_data[0];
                CFG_BLEND_FACTOR:  blend_factor_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // column/row tracking and neighbour classification
    hnsu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .region_width  (region_width_reg),
        .region_height (region_height_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .q_full        (q_full),
        .push          (push),
        .push_flags    (push_flags),
        .push_col      (push_col),
        .push_sample   (push_sample),
        .push_weight   (push_weight)
    );

    // short queue decouples intake from the slow averaging path
    hnsu_queue #(.COL_W(COL_W)) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_flags  (push_flags),
        .push_col    (push_col),
        .push_sample (push_sample),
        .push_weight (push_weight),
        .full        (q_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_flags  (head_flags),
        .head_col    (head_col),
        .head_sample (head_sample),
        .head_weight (head_weight)
    );

    // line buffers, averaging, blend and output register
    hnsu_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .brush_mode   (brush_mode_reg),
        .blend_factor (blend_factor_reg),
        .head_valid   (head_valid),
        .head_flags   (head_flags),
        .head_col     (head_col),
        .head_sample  (head_sample),
        .head_weight  (head_weight),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule
